// ===== hw/rtl/timed_operation_sequencer_unit_assert.svh =====
// Assertion macros for the timed operation sequencer unit.
`ifndef TIMED_OPERATION_SEQUENCER_UNIT_ASSERT_SVH
`define TIMED_OPERATION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TOSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tosu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TOSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tosu: next-cycle check failed");

`endif

// ===== hw/rtl/tosu_pkg.sv =====
// Package: shared types and constants of the timed operation sequencer.
`default_nettype none
package tosu_pkg;

    localparam int TIME_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PROG_W      = 17;
    localparam int KIND_W      = 2;
    localparam int IDX_OUT_W   = 4;
    localparam int DIV_W       = 64;
    localparam int MAX_OPS_DEF = 16;

    localparam logic [PROG_W-1:0] FRAC_ONE = PROG_W'(1) << FRAC_W;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_START  = 3'd2,
        OP_TICK   = 3'd3,
        OP_FINISH = 3'd4,
        OP_ABORT  = 3'd5,
        OP_PAUSE  = 3'd6,
        OP_RESUME = 3'd7
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        EV_INIT    = 2'd0,
        EV_PERFORM = 2'd1,
        EV_FINISH  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NE_CHK,
        ST_NE_CMP,
        ST_NE_END,
        ST_ACT_CHK,
        ST_ACT_CMP,
        ST_ACT_DIV,
        ST_ACT_EMIT,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 emit;
        logic                 flush;
        kind_t                kind;
        logic [IDX_OUT_W-1:0] idx;
        logic [PROG_W-1:0]    prog;
    } emit_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tosu_div.sv =====
// Serial fractional divider: floor(a * 2^FRAC_W / b), one quotient bit per subtract/compare step.
`default_nettype none
module tosu_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tosu_pkg::DIV_W-1:0]   a,
    input  wire logic [tosu_pkg::DIV_W-1:0]   b,
    output logic                              done,
    output logic [tosu_pkg::FRAC_W-1:0]       q
);
    localparam int CW = $clog2(tosu_pkg::FRAC_W);

    logic                        busy_reg, busy_next;
    logic                        phase_reg, phase_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [tosu_pkg::DIV_W-1:0]  a_reg, a_next;
    logic [tosu_pkg::DIV_W-1:0]  b_reg, b_next;
    logic [tosu_pkg::DIV_W-1:0]  d_reg, d_next;
    logic [tosu_pkg::FRAC_W-1:0] q_reg, q_next;
    logic                        ge;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        ge         = (a_reg >= d_reg);
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            a_next     = a;
            b_next     = b;
            q_next     = '0;
        end
        else if (busy_reg && !phase_reg)
        begin
            d_next     = b_reg - a_reg;
            phase_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next     = {q_reg[tosu_pkg::FRAC_W-2:0], ge};
            a_next     = ge ? (a_reg - d_reg) : (a_reg + a_reg);
            phase_next = 1'b0;
            cnt_next   = cnt_reg + CW'(1);
            if (cnt_reg == CW'(tosu_pkg::FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        d_reg <= d_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/tosu_out.sv =====
// Result staging: one held event plus the output register; marks the last event.
`default_nettype none
`include "timed_operation_sequencer_unit_assert.svh"
module tosu_out (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tosu_pkg::emit_req_t                 req,
    output logic                                     emit_ok,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [tosu_pkg::KIND_W-1:0]              event_kind,
    output logic [tosu_pkg::IDX_OUT_W-1:0]           op_index,
    output logic [tosu_pkg::PROG_W-1:0]              progress,
    output logic                                     last
);
    logic                           hold_valid_reg, hold_valid_next;
    tosu_pkg::emit_req_t            hold_reg, hold_next;
    logic                           out_valid_reg, out_valid_next;
    tosu_pkg::emit_req_t            out_reg, out_next;
    logic                           last_reg, last_next;
    logic                           out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        emit_ok         = !hold_valid_reg || out_free;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        if (req.emit && emit_ok)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                last_next      = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = req;
        end
        else if (req.flush && emit_ok && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            last_next       = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_reg.kind;
    assign op_index   = out_reg.idx;
    assign progress   = out_reg.prog;
    assign last       = last_reg;

    `TOSU_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && out_stall,
        out_valid_reg && $stable(out_reg) && $stable(last_reg))
    `TOSU_ASSERT_IMPLY(a_no_overrun, clk, rst_n, hold_valid_reg && out_valid_reg && out_stall,
        !emit_ok)
    `TOSU_ASSERT_NEXT(a_flush_empties, clk, rst_n, req.flush && emit_ok && !req.emit,
        !hold_valid_reg)
endmodule
`default_nettype wire

// ===== hw/rtl/timed_operation_sequencer_unit.sv =====
// Top level: timeline table, run control and event sequencer.
`default_nettype none
`include "timed_operation_sequencer_unit_assert.svh"
// Timed operation sequencer. Holds a table of up to MAX_OPS timeline entries
// (start/end tick pairs, loaded in order with op 0) and steps through them on
// each tick transfer. A tick walks the not-yet-reached entries, then the
// in-progress list, one entry at a time through a single-read table port,
// and emits init, perform (Q16 progress) and finished events in model order;
// the final event of an item carries last=1. Progress comes from one shared
// serial divider. Control ops (add, clear, start, pause, resume, abort, and
// ignored ticks) complete without leaving the idle state. Output
// back-pressure lengthens a tick. in_stall stays high while an item is being
// worked. The user must write the timeline length through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this. The
// table has no reset; entries read before being added are meaningless.
module timed_operation_sequencer_unit #(
    parameter int MAX_OPS = tosu_pkg::MAX_OPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [tosu_pkg::TIME_W-1:0]        cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         op,
    input  wire logic [tosu_pkg::TIME_W-1:0]        time_now,
    input  wire logic [tosu_pkg::TIME_W-1:0]        delay,
    input  wire logic [tosu_pkg::TIME_W-1:0]        entry_start,
    input  wire logic [tosu_pkg::TIME_W-1:0]        entry_end,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [tosu_pkg::KIND_W-1:0]             event_kind,
    output logic [tosu_pkg::IDX_OUT_W-1:0]          op_index,
    output logic [tosu_pkg::PROG_W-1:0]             progress,
    output logic                                    last
);
    localparam int IDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CNT_W = $clog2(MAX_OPS + 1);
    localparam int TW    = tosu_pkg::TIME_W;

    // run control
    tosu_pkg::state_t state_reg, state_next;
    logic [TW-1:0]    len_limit_reg;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [CNT_W-1:0] next_entry_reg, next_entry_next;
    logic             running_reg, running_next;
    logic [CNT_W-1:0] active_count_reg, active_count_next;
    logic [CNT_W-1:0] act_i_reg, act_i_next;
    logic [TW-1:0]    base_time_reg, base_time_next;
    logic [TW-1:0]    pause_time_reg, pause_time_next;
    logic [TW-1:0]    rel_reg, rel_next;
    logic             force_reg, force_next;

    // timeline table, one registered read port
    logic [TW-1:0]    starts_mem [MAX_OPS];
    logic [TW-1:0]    ends_mem   [MAX_OPS];
    logic [TW-1:0]    rd_start_reg, rd_end_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    // in-progress list
    logic [IDX_W-1:0] active_list_reg [MAX_OPS];
    logic             list_append;
    logic             list_remove;

    // shared divider and result stage
    logic                          div_start;
    logic [tosu_pkg::DIV_W-1:0]    div_a, div_b;
    logic                          div_done;
    logic [tosu_pkg::FRAC_W-1:0]   div_q;
    tosu_pkg::emit_req_t           req;
    logic                          emit_ok;
    logic                          in_xfer;
    tosu_pkg::op_t                 op_code;

    assign in_stall = (state_reg != tosu_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign op_code  = tosu_pkg::op_t'(op);
    assign div_a    = tosu_pkg::DIV_W'(rel_reg) - tosu_pkg::DIV_W'(rd_start_reg);
    assign div_b    = tosu_pkg::DIV_W'(rd_end_reg) - tosu_pkg::DIV_W'(rd_start_reg);

    always_comb
    begin
        state_next        = state_reg;
        entry_count_next  = entry_count_reg;
        next_entry_next   = next_entry_reg;
        running_next      = running_reg;
        active_count_next = active_count_reg;
        act_i_next        = act_i_reg;
        base_time_next    = base_time_reg;
        pause_time_next   = pause_time_reg;
        rel_next          = rel_reg;
        force_next        = force_reg;
        rd_en             = 1'b0;
        rd_addr           = next_entry_reg[IDX_W-1:0];
        wr_en             = 1'b0;
        list_append       = 1'b0;
        list_remove       = 1'b0;
        div_start         = 1'b0;
        req               = '0;
        req.kind          = tosu_pkg::EV_INIT;
        req.idx           = tosu_pkg::IDX_OUT_W'(cur_idx_reg);

        case (state_reg)
            tosu_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (op_code)
                        tosu_pkg::OP_ADD:
                        begin
                            if (entry_count_reg < CNT_W'(MAX_OPS))
                            begin
                                wr_en            = 1'b1;
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end
                        tosu_pkg::OP_CLEAR:
                        begin
                            entry_count_next  = '0;
                            next_entry_next   = '0;
                            running_next      = 1'b0;
                            active_count_next = '0;
                        end
                        tosu_pkg::OP_START:
                        begin
                            if (!running_reg)
                            begin
                                running_next      = 1'b1;
                                next_entry_next   = '0;
                                active_count_next = '0;
                                base_time_next    = time_now + delay;
                            end
                        end
                        tosu_pkg::OP_TICK:
                        begin
                            if (running_reg && pause_time_reg == '0 &&
                                time_now >= base_time_reg)
                            begin
                                rel_next   = time_now - base_time_reg;
                                force_next = 1'b0;
                                act_i_next = '0;
                                state_next = tosu_pkg::ST_NE_CHK;
                            end
                        end
                        tosu_pkg::OP_FINISH:
                        begin
                            if (running_reg)
                            begin
                                // one past the end, saturated at the time range
                                rel_next   = (len_limit_reg == tosu_pkg::TIME_MAX) ?
                                             tosu_pkg::TIME_MAX : len_limit_reg + TW'(1);
                                force_next = 1'b1;
                                act_i_next = '0;
                                state_next = tosu_pkg::ST_NE_CHK;
                            end
                        end
                        tosu_pkg::OP_ABORT:
                        begin
                            running_next      = 1'b0;
                            active_count_next = '0;
                        end
                        tosu_pkg::OP_PAUSE:
                        begin
                            if (pause_time_reg == '0)
                                pause_time_next = (time_now == '0) ? TW'(1) : time_now;
                        end
                        tosu_pkg::OP_RESUME:
                        begin
                            if (pause_time_reg != '0)
                            begin
                                base_time_next  = base_time_reg + (time_now - pause_time_reg);
                                pause_time_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = tosu_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tosu_pkg::ST_NE_CHK:
            begin
                if (next_entry_reg < entry_count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = tosu_pkg::ST_NE_CMP;
                end
                else
                    state_next = tosu_pkg::ST_ACT_CHK;
            end
            tosu_pkg::ST_NE_CMP:
            begin
                if (rel_reg >= rd_start_reg)
                begin
                    req.emit = 1'b1;
                    req.kind = tosu_pkg::EV_INIT;
                    if (emit_ok)
                        state_next = tosu_pkg::ST_NE_END;
                end
                else
                    state_next = tosu_pkg::ST_ACT_CHK;
            end
            tosu_pkg::ST_NE_END:
            begin
                if (rel_reg >= rd_end_reg)
                begin
                    req.emit = 1'b1;
                    req.kind = tosu_pkg::EV_PERFORM;
                    req.prog = tosu_pkg::FRAC_ONE;
                end
                if (!req.emit || emit_ok)
                begin
                    if (!req.emit && active_count_reg < CNT_W'(MAX_OPS))
                    begin
                        list_append       = 1'b1;
                        active_count_next = active_count_reg + CNT_W'(1);
                    end
                    next_entry_next = next_entry_reg + CNT_W'(1);
                    state_next      = tosu_pkg::ST_NE_CHK;
                end
            end
            tosu_pkg::ST_ACT_CHK:
            begin
                if (act_i_reg < active_count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = active_list_reg[act_i_reg[IDX_W-1:0]];
                    state_next = tosu_pkg::ST_ACT_CMP;
                end
                else
                    state_next = tosu_pkg::ST_FIN;
            end
            tosu_pkg::ST_ACT_CMP:
            begin
                if (rel_reg >= rd_end_reg)
                begin
                    req.emit = 1'b1;
                    req.kind = tosu_pkg::EV_PERFORM;
                    req.prog = tosu_pkg::FRAC_ONE;
                    if (emit_ok)
                    begin
                        list_remove       = 1'b1;
                        active_count_next = active_count_reg - CNT_W'(1);
                        state_next        = tosu_pkg::ST_ACT_CHK;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = tosu_pkg::ST_ACT_DIV;
                end
            end
            tosu_pkg::ST_ACT_DIV:
            begin
                if (div_done)
                    state_next = tosu_pkg::ST_ACT_EMIT;
            end
            tosu_pkg::ST_ACT_EMIT:
            begin
                req.emit = 1'b1;
                req.kind = tosu_pkg::EV_PERFORM;
                req.prog = tosu_pkg::PROG_W'(div_q);
                if (emit_ok)
                begin
                    act_i_next = act_i_reg + CNT_W'(1);
                    state_next = tosu_pkg::ST_ACT_CHK;
                end
            end
            tosu_pkg::ST_FIN:
            begin
                if (force_reg || rel_reg > len_limit_reg)
                begin
                    req.emit = 1'b1;
                    req.kind = tosu_pkg::EV_FINISH;
                    req.idx  = '0;
                    if (emit_ok)
                    begin
                        running_next      = 1'b0;
                        active_count_next = '0;
                        state_next        = tosu_pkg::ST_DONE;
                    end
                end
                else
                    state_next = tosu_pkg::ST_DONE;
            end
            tosu_pkg::ST_DONE:
            begin
                // push the held event out marked as last
                req.flush = 1'b1;
                if (emit_ok)
                    state_next = tosu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tosu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tosu_pkg::ST_IDLE;
            len_limit_reg    <= '0;
            entry_count_reg  <= '0;
            next_entry_reg   <= '0;
            running_reg      <= 1'b0;
            active_count_reg <= '0;
            act_i_reg        <= '0;
            base_time_reg    <= '0;
            pause_time_reg   <= '0;
            rel_reg          <= '0;
            force_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_limit_reg    <= cfg_we ? cfg_wdata : len_limit_reg;
            entry_count_reg  <= entry_count_next;
            next_entry_reg   <= next_entry_next;
            running_reg      <= running_next;
            active_count_reg <= active_count_next;
            act_i_reg        <= act_i_next;
            base_time_reg    <= base_time_next;
            pause_time_reg   <= pause_time_next;
            rel_reg          <= rel_next;
            force_reg        <= force_next;
        end
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            starts_mem[entry_count_reg[IDX_W-1:0]] <= entry_start;
            ends_mem[entry_count_reg[IDX_W-1:0]]   <= entry_end;
        end
        if (rd_en)
        begin
            rd_start_reg <= starts_mem[rd_addr];
            rd_end_reg   <= ends_mem[rd_addr];
            cur_idx_reg  <= rd_addr;
        end
    end

    // in-progress list: append at the tail, close the gap on removal
    always_ff @(posedge clk)
    begin
        if (list_append)
            active_list_reg[active_count_reg[IDX_W-1:0]] <= next_entry_reg[IDX_W-1:0];
        if (list_remove)
        begin
            for (int k = 0; k < MAX_OPS - 1; k++)
            begin
                if (CNT_W'(k) >= act_i_reg)
                    active_list_reg[k] <= active_list_reg[k + 1];
            end
        end
    end

    tosu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q)
    );

    tosu_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .emit_ok    (emit_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .op_index   (op_index),
        .progress   (progress),
        .last       (last)
    );

    `TOSU_ASSERT_IMPLY(a_count_order, clk, rst_n, 1'b1,
        active_count_reg <= next_entry_reg && next_entry_reg <= entry_count_reg)
    `TOSU_ASSERT_IMPLY(a_idle_list_empty, clk, rst_n, !running_reg, active_count_reg == '0)
    `TOSU_ASSERT_IMPLY(a_div_done_where, clk, rst_n, div_done,
        state_reg == tosu_pkg::ST_ACT_DIV)
endmodule
`default_nettype wire
